/* src/bhp_pkg.sv */
// Shared types and constants for the brightness histogram percentile block.
package bhp_pkg;

  localparam int BIN_COUNT = 256;
  localparam int BIN_W = 8;
  localparam int SUB_W = 5;
  localparam int PCT_W = 16;

  typedef enum logic [1:0] {
    ACT_CLEAR     = 2'd0,
    ACT_PIXEL     = 2'd1,
    ACT_QUERY     = 2'd2,
    ACT_NEW_IMAGE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DESIRE,
    ST_WALK,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic             clear;
    logic             we;
    logic [BIN_W-1:0] waddr;
    logic [BIN_W-1:0] raddr;
  } bin_ctrl_t;

endpackage

/* src/bhp_bins.sv */
// Bin count memory with per-entry valid bits and a registered read port.
module bhp_bins #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bhp_pkg::bin_ctrl_t     ctrl,
  input  logic [COUNT_WIDTH-1:0] wdata,
  output logic [COUNT_WIDTH-1:0] rdata
);

  logic [COUNT_WIDTH-1:0]        mem [bhp_pkg::BIN_COUNT];
  logic [bhp_pkg::BIN_COUNT-1:0] valid;
  logic [COUNT_WIDTH-1:0]        rdata_raw;
  logic                          rvld;

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[ctrl.waddr] <= wdata;
    end
    rdata_raw <= mem[ctrl.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= '0;
    end else if (ctrl.we) begin
      valid[ctrl.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvld <= 1'b0;
    end else begin
      rvld <= valid[ctrl.raddr];
    end
  end

  assign rdata = rvld ? rdata_raw : '0;

endmodule

/* src/brightness_histogram_percentile.sv */
// Top level of the 256-bin brightness histogram with percentile query.
//
// Input beats arrive on s_axis: tuser carries the action (clear, pixel, query,
// start of image), tlast marks the last pixel of a row, and tdata carries
// pixel, weight and percentile. A query gives one beat on m_axis: tdata is
// the brightness value, tuser the empty-histogram flag.
// Pixels, clears and start-of-image beats are taken one per cycle while the block is idle.
// A pixel update reads its bin, adds and writes back in the following cycle; a same-bin
// pixel in the next cycle is forwarded from the write stage.
// A query on an empty histogram goes from idle straight to the hold state.
// Otherwise it passes through the desire, walk (1 to 256 bins) and hold states,
// one bin read from the memory port per cycle; no input is accepted during the walk.
// Clear needs no clearing pass: per-bin valid bits are dropped at once.
// Reset zeroes bins, total and phases and sets subsample to 1. A stalled result
// waits in the output register while pixels continue; a later query holds
// until that result is taken.
// cfg_wr_en writes subsample; write it only while the block is idle.
module brightness_histogram_percentile #(
  parameter int COUNT_WIDTH   = 32,
  parameter int MAX_SUBSAMPLE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pixel[7:0], weight[15:8], percentile[31:16]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  input  logic        s_axis_tlast,   // end_of_row
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // value[7:0]
  output logic [0:0]  m_axis_tuser    // histogram_empty[0]
);

  localparam int PHASE_W = (MAX_SUBSAMPLE > 1) ? $clog2(MAX_SUBSAMPLE) : 1;
  localparam int CMP_W   = PHASE_W + 6;
  localparam int CUM_W   = COUNT_WIDTH + bhp_pkg::BIN_W;
  localparam int PROD_W  = COUNT_WIDTH + bhp_pkg::PCT_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);
  localparam logic [bhp_pkg::BIN_W-1:0] LAST_BIN = '1;

  bhp_pkg::state_t    state, state_next;
  bhp_pkg::action_t   action;
  bhp_pkg::bin_ctrl_t bin_ctrl;

  logic [bhp_pkg::SUB_W-1:0] subsample;
  logic [COUNT_WIDTH-1:0]    total;
  logic [PHASE_W-1:0]        row_phase, col_phase;

  logic [bhp_pkg::BIN_W-1:0] in_pixel;
  logic [7:0]                in_weight;
  logic [bhp_pkg::PCT_W-1:0] in_pct;
  logic                      accept;

  logic [CMP_W-1:0]   sub_ext, sub_eff;
  logic [PHASE_W-1:0] row_step, col_step;
  logic               take;

  logic                      upd_valid;
  logic [bhp_pkg::BIN_W-1:0] upd_addr;
  logic [7:0]                upd_weight;
  logic                      fwd_hit;
  logic [COUNT_WIDTH-1:0]    fwd_data;
  logic [COUNT_WIDTH-1:0]    bin_rdata, upd_old, upd_new;
  logic [COUNT_WIDTH:0]      upd_sum, total_sum;

  logic [bhp_pkg::PCT_W-1:0] q_pct;
  logic [COUNT_WIDTH-1:0]    desired;
  logic [PROD_W-1:0]         prod;
  logic [CUM_W-1:0]          cum;
  logic [bhp_pkg::BIN_W-1:0] walk_bin;
  logic                      walk_hit, walk_done;
  logic [bhp_pkg::BIN_W-1:0] walk_val;
  logic [bhp_pkg::BIN_W-1:0] res_value;
  logic                      res_empty;
  logic                      out_free;

  assign in_pixel  = s_axis_tdata[7:0];
  assign in_weight = s_axis_tdata[15:8];
  assign in_pct    = s_axis_tdata[31:16];
  assign action    = bhp_pkg::action_t'(s_axis_tuser);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // effective subsample and phase steps
  always_comb begin
    sub_ext = CMP_W'(subsample);
    sub_eff = sub_ext;
    if (sub_ext == '0) begin
      sub_eff = CMP_W'(1);
    end else if (sub_ext > CMP_W'(MAX_SUBSAMPLE)) begin
      sub_eff = CMP_W'(MAX_SUBSAMPLE);
    end
    row_step = ((CMP_W'(row_phase) + CMP_W'(1)) >= sub_eff) ? '0 : row_phase + 1'b1;
    col_step = ((CMP_W'(col_phase) + CMP_W'(1)) >= sub_eff) ? '0 : col_phase + 1'b1;
  end

  assign take = (row_phase == '0) && (col_phase == '0) && (in_weight != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      subsample <= bhp_pkg::SUB_W'(1);
    end else if (cfg_wr_en) begin
      subsample <= cfg_wr_data;
    end
  end

  // control FSM
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    unique case (state)
      bhp_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && action == bhp_pkg::ACT_QUERY) begin
          state_next = (total == '0) ? bhp_pkg::ST_HOLD : bhp_pkg::ST_DESIRE;
        end
      end
      bhp_pkg::ST_DESIRE: state_next = bhp_pkg::ST_WALK;
      bhp_pkg::ST_WALK: begin
        if (walk_done) begin
          state_next = bhp_pkg::ST_HOLD;
        end
      end
      bhp_pkg::ST_HOLD: begin
        if (out_free) begin
          state_next = bhp_pkg::ST_IDLE;
        end
      end
      default: state_next = bhp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bhp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // bin read-modify-write
  assign upd_old   = fwd_hit ? fwd_data : bin_rdata;
  assign upd_sum   = {1'b0, upd_old} + (COUNT_WIDTH + 1)'(upd_weight);
  assign upd_new   = upd_sum[COUNT_WIDTH] ? COUNT_MAX : upd_sum[COUNT_WIDTH-1:0];
  assign total_sum = {1'b0, total} + (COUNT_WIDTH + 1)'(in_weight);

  always_comb begin
    bin_ctrl.clear = accept && action == bhp_pkg::ACT_CLEAR;
    bin_ctrl.we    = upd_valid;
    bin_ctrl.waddr = upd_addr;
    unique case (state)
      bhp_pkg::ST_DESIRE: bin_ctrl.raddr = '0;
      bhp_pkg::ST_WALK:   bin_ctrl.raddr = walk_bin + 1'b1;
      default:            bin_ctrl.raddr = in_pixel;
    endcase
  end

  bhp_bins #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_bins (
    .clk  (clk),
    .rst  (rst),
    .ctrl (bin_ctrl),
    .wdata(upd_new),
    .rdata(bin_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_valid <= 1'b0;
      fwd_hit   <= 1'b0;
      total     <= '0;
      row_phase <= '0;
      col_phase <= '0;
    end else begin
      upd_valid <= 1'b0;
      fwd_hit   <= 1'b0;
      if (accept) begin
        case (action)
          bhp_pkg::ACT_CLEAR: total <= '0;
          bhp_pkg::ACT_NEW_IMAGE: begin
            row_phase <= '0;
            col_phase <= '0;
          end
          bhp_pkg::ACT_PIXEL: begin
            if (take) begin
              upd_valid <= 1'b1;
              fwd_hit   <= upd_valid && (upd_addr == in_pixel);
              total     <= total_sum[COUNT_WIDTH] ? COUNT_MAX
                                                  : total_sum[COUNT_WIDTH-1:0];
            end
            if (s_axis_tlast) begin
              col_phase <= '0;
              row_phase <= row_step;
            end else begin
              col_phase <= col_step;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && action == bhp_pkg::ACT_PIXEL) begin
      upd_addr   <= in_pixel;
      upd_weight <= in_weight;
      fwd_data   <= upd_new;
    end
  end

  // percentile walk
  assign prod      = PROD_W'(q_pct) * PROD_W'(total) + ROUND_HALF;
  assign walk_hit  = cum >= CUM_W'(desired);
  assign walk_done = walk_hit || (walk_bin == LAST_BIN);
  assign walk_val  = walk_hit ? walk_bin : LAST_BIN;

  always_ff @(posedge clk) begin
    case (state)
      bhp_pkg::ST_IDLE: begin
        if (accept && action == bhp_pkg::ACT_QUERY) begin
          q_pct     <= in_pct;
          res_value <= '0;
          res_empty <= (total == '0);
        end
      end
      bhp_pkg::ST_DESIRE: begin
        desired  <= prod[PROD_W-1:bhp_pkg::PCT_W];
        cum      <= '0;
        walk_bin <= '0;
      end
      bhp_pkg::ST_WALK: begin
        if (walk_done) begin
          res_value <= walk_val;
        end else begin
          cum      <= cum + CUM_W'(bin_rdata);
          walk_bin <= walk_bin + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == bhp_pkg::ST_HOLD && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bhp_pkg::ST_HOLD && out_free) begin
      m_axis_tdata <= res_value;
      m_axis_tuser <= res_empty;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (CMP_W'(row_phase) < CMP_W'(MAX_SUBSAMPLE)) && (CMP_W'(col_phase) < CMP_W'(MAX_SUBSAMPLE)))
    else $error("phase counter out of range");

  a_upd_idle: assert property (@(posedge clk) disable iff (rst)
    upd_valid |-> state == bhp_pkg::ST_IDLE)
    else $error("bin update pending outside idle");

  a_empty_query: assert property (@(posedge clk) disable iff (rst)
    (accept && action == bhp_pkg::ACT_QUERY && total == '0) |=> state == bhp_pkg::ST_HOLD)
    else $error("empty query did not go straight to result");

  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata == '0)
    else $error("empty result carries nonzero value");

endmodule
